// ===== rtl/u2u_pkg.sv =====
package u2u_pkg;

    // lead byte lengths
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // continuation bytes still owed after each lead
    localparam logic [1:0] OWED_NONE  = 2'd0;
    localparam logic [1:0] OWED_ONE   = 2'd1;
    localparam logic [1:0] OWED_TWO   = 2'd2;
    localparam logic [1:0] OWED_THREE = 2'd3;

    typedef struct packed {
        logic [1:0]  owed;
        logic [15:0] partial;
        logic [2:0]  seq_len;
        logic        unsup;
    } u2u_state_t;

    typedef struct packed {
        logic        emit;
        logic [15:0] code_unit;
        logic [2:0]  byte_count;
        logic        unsupported;
        logic        last_unit;
    } u2u_result_t;

    localparam u2u_state_t STATE_RESET = '{
        owed:    OWED_NONE,
        partial: 16'h0000,
        seq_len: LEN_ONE,
        unsup:   1'b0
    };

endpackage

// ===== rtl/u2u_step.sv =====
module u2u_step
    import u2u_pkg::*;
(
    input  u2u_state_t  state_cur,
    input  logic [7:0]  byte_in,
    input  logic        end_of_string,
    output u2u_state_t  state_next,
    output u2u_result_t result
);

    u2u_state_t  upd;
    logic        check_done;
    logic [15:0] cont_bits;

    always_comb begin
        upd        = state_cur;
        check_done = 1'b0;
        result     = '0;
        // second-to-last byte of a 3-byte sequence lands six bits up
        cont_bits  = (state_cur.owed == OWED_TWO) ? {4'b0, byte_in[5:0], 6'b0}
                                                  : {10'b0, byte_in[5:0]};

        if (state_cur.owed == OWED_NONE) begin
            case (byte_in) inside
                8'b0???????: begin
                    result.emit        = 1'b1;
                    result.code_unit   = {8'b0, byte_in};
                    result.byte_count  = LEN_ONE;
                    result.unsupported = 1'b0;
                    result.last_unit   = end_of_string;
                end
                8'b110?????: begin
                    upd.partial = {5'b0, byte_in[4:0], 6'b0};
                    upd.owed    = OWED_ONE;
                    upd.seq_len = LEN_TWO;
                    upd.unsup   = 1'b0;
                    check_done  = 1'b1;
                end
                8'b1110????: begin
                    upd.partial = {byte_in[3:0], 12'b0};
                    upd.owed    = OWED_TWO;
                    upd.seq_len = LEN_THREE;
                    upd.unsup   = 1'b0;
                    check_done  = 1'b1;
                end
                8'b11110???: begin
                    upd.partial = 16'h0000;
                    upd.owed    = OWED_THREE;
                    upd.seq_len = LEN_FOUR;
                    upd.unsup   = 1'b1;
                    check_done  = 1'b1;
                end
                default: begin
                    // stray continuation or 11111xxx lead
                    result.emit        = 1'b1;
                    result.code_unit   = 16'h0000;
                    result.byte_count  = LEN_ONE;
                    result.unsupported = 1'b1;
                    result.last_unit   = end_of_string;
                end
            endcase
        end else begin
            if (!state_cur.unsup) begin
                upd.partial = state_cur.partial | cont_bits;
            end
            upd.owed   = state_cur.owed - 2'd1;
            check_done = 1'b1;
        end

        state_next = upd;
        if (check_done && (upd.owed == OWED_NONE || end_of_string)) begin
            result.emit        = 1'b1;
            result.code_unit   = upd.unsup ? 16'h0000 : upd.partial;
            result.byte_count  = upd.seq_len;
            result.unsupported = upd.unsup;
            result.last_unit   = end_of_string;
            state_next         = STATE_RESET;
        end
    end

endmodule

// ===== rtl/utf8_to_ucs2_decoder.sv =====
// channel | direction | tdata                          | tuser        | tlast
// s_      | in        | byte_in[7:0]                   | -            | end_of_string
// m_      | out       | code_unit[15:0], byte_count    | unsupported  | last_unit
//
// one byte word is taken per clock while s_tready is high; the decode is one pass of logic between
// the sequence state register and the output register
// a character is registered and shows on m_ in the cycle after its final byte (or the end-of-string byte)
// aresetn is synchronous, active low; it clears the sequence state and m_tvalid
// s_tready drops only while a result sits in the output register and m_tready is low
module utf8_to_ucs2_decoder
    import u2u_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // end_of_string

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] code_unit, [18:16] byte_count, [23:19] zero
    output logic [0:0]  m_tuser,   // [0] unsupported
    output logic        m_tlast    // last_unit
);

    u2u_state_t  state_reg;
    u2u_state_t  state_next;
    u2u_result_t step_res;

    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [15:0] code_unit_reg;
    logic [2:0]  byte_count_reg;
    logic        unsupported_reg;
    logic        last_unit_reg;
    logic        s_accept;

    // input side runs while the output register is empty or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    u2u_step u_step (
        .state_cur     (state_reg),
        .byte_in       (s_tdata),
        .end_of_string (s_tlast),
        .state_next    (state_next),
        .result        (step_res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_tready) begin
            m_tvalid_next = s_accept && step_res.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= STATE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, loaded only when a character completes
    always_ff @(posedge aclk) begin
        if (s_accept && step_res.emit) begin
            code_unit_reg   <= step_res.code_unit;
            byte_count_reg  <= step_res.byte_count;
            unsupported_reg <= step_res.unsupported;
            last_unit_reg   <= step_res.last_unit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, byte_count_reg, code_unit_reg};
    assign m_tuser  = unsupported_reg;
    assign m_tlast  = last_unit_reg;

    // unsupported sequences always carry a zero code unit
    a_unsup_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[15:0] == 16'h0000)
        else $error("unsupported word with nonzero code unit");

    // the end-of-string byte always leaves the decoder at its reset state
    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=>
            state_reg.owed == OWED_NONE && state_reg.seq_len == LEN_ONE
            && !state_reg.unsup)
        else $error("sequence state not cleared after end of string");

    // a sequence in flight always knows a multi-byte length
    a_len_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.owed != OWED_NONE |->
            state_reg.seq_len == LEN_TWO || state_reg.seq_len == LEN_THREE
            || state_reg.seq_len == LEN_FOUR)
        else $error("pending bytes with a one-byte length");

    // an end-of-string byte produces a word at once
    a_eos_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid && m_tlast)
        else $error("end of string produced no last word");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
    import u2u_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;   // far above the slowest correct run
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off
    localparam int PRINT_CAP   = 40;       // mismatch lines printed before going quiet

    // character kinds for the text generator
    typedef enum int {
        CH_ASCII,
        CH_TWO,
        CH_THREE,
        CH_FOUR,
        CH_BAD_LEAD
    } char_kind_t;

    // one decoded word as seen on the result channel
    typedef struct packed {
        logic [15:0] code_unit;
        logic [2:0]  byte_count;
        logic        unsupported;
        logic        last_unit;
    } ucs2_word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] byte_in
    logic        s_tlast;    // end_of_string
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [15:0] code_unit, [18:16] byte_count, [23:19] zero
    logic [0:0]  m_tuser;    // [0] unsupported
    logic        m_tlast;    // last_unit

    // expected decoded words, oldest first
    ucs2_word_t expected_units[$];

    // decoder state mirror, starts at the reset values
    logic [1:0]  dec_owed    = STATE_RESET.owed;
    logic [15:0] dec_partial = STATE_RESET.partial;
    logic [2:0]  dec_len     = STATE_RESET.seq_len;
    logic        dec_unsup   = STATE_RESET.unsup;

    int  error_count = 0;
    int  units_seen  = 0;
    int  bytes_sent  = 0;
    int  cycle_count = 0;
    bit  idle_on     = 1'b0;   // random gaps on both sides
    bit  hold_req    = 1'b0;   // ask the receiver for one long hold-off

    ucs2_word_t got_unit;
    ucs2_word_t want_unit;

    utf8_to_ucs2_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_units.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // one line per mismatch up to PRINT_CAP, every mismatch counted
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch at word %0d: %s got 0x%0h want 0x%0h",
                     units_seen, what, got, want);
    endtask

    // advance the decoder mirror by one byte; returns 1 when a word comes out
    function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                       output ucs2_word_t w);
        w = '0;
        if (dec_owed == OWED_NONE) begin
            if (b[7] == 1'b0) begin
                // plain ascii passes straight through
                w = '{code_unit: {8'h00, b}, byte_count: LEN_ONE,
                      unsupported: 1'b0, last_unit: eos};
                return 1'b1;
            end else if (b[7:5] == 3'b110) begin
                dec_partial = {5'd0, b[4:0], 6'd0};
                dec_owed    = OWED_ONE;
                dec_len     = LEN_TWO;
                dec_unsup   = 1'b0;
            end else if (b[7:4] == 4'b1110) begin
                dec_partial = {b[3:0], 12'd0};
                dec_owed    = OWED_TWO;
                dec_len     = LEN_THREE;
                dec_unsup   = 1'b0;
            end else if (b[7:3] == 5'b11110) begin
                // four-byte lead, beyond ucs-2: trailing bytes are swallowed
                dec_partial = 16'h0000;
                dec_owed    = OWED_THREE;
                dec_len     = LEN_FOUR;
                dec_unsup   = 1'b1;
            end else begin
                // stray continuation or 11111xxx lead stands alone as bad
                w = '{code_unit: 16'h0000, byte_count: LEN_ONE,
                      unsupported: 1'b1, last_unit: eos};
                return 1'b1;
            end
        end else begin
            // trailing byte, the 10 prefix is not checked
            if (!dec_unsup)
                dec_partial = dec_partial |
                    ((dec_owed == OWED_TWO) ? {4'd0, b[5:0], 6'd0} : {10'd0, b[5:0]});
            dec_owed = dec_owed - 2'd1;
        end
        // complete, or cut short by the end of the string
        if (dec_owed == OWED_NONE || eos) begin
            w = '{code_unit: dec_unsup ? 16'h0000 : dec_partial, byte_count: dec_len,
                  unsupported: dec_unsup, last_unit: eos};
            dec_owed    = STATE_RESET.owed;
            dec_partial = STATE_RESET.partial;
            dec_len     = STATE_RESET.seq_len;
            dec_unsup   = STATE_RESET.unsup;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // offer one byte word, called at a rising edge, returns at the accepting edge
    task automatic send_byte(input logic [7:0] b, input logic eos);
        ucs2_word_t w;
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (decode_byte(b, eos, w))
            expected_units = {expected_units, w};
    endtask

    // trailing byte, now and then without the 10 prefix
    function automatic logic [7:0] trail_byte();
        logic [7:0] r;
        r = 8'($urandom);
        if ($urandom_range(0, 15) == 0)
            return r;
        return {2'b10, r[5:0]};
    endfunction

    // one character of the given kind; the string may be cut short on its last one
    task automatic send_char(input char_kind_t kind, input bit ends_string);
        logic [7:0] seq_bytes[4];
        logic [7:0] r;
        int len;
        int cut;
        r = 8'($urandom);
        len = 1;
        case (kind)
            CH_ASCII: begin
                seq_bytes[0] = {1'b0, r[6:0]};
            end
            CH_TWO: begin
                seq_bytes[0] = {3'b110, r[4:0]};
                len = 2;
            end
            CH_THREE: begin
                seq_bytes[0] = {4'b1110, r[3:0]};
                len = 3;
            end
            CH_FOUR: begin
                seq_bytes[0] = {5'b11110, r[2:0]};
                len = 4;
            end
            default: begin
                seq_bytes[0] = r[0] ? {2'b10, r[6:1]} : {5'b11111, r[3:1]};
            end
        endcase
        for (int i = 1; i < len; i++)
            seq_bytes[i] = trail_byte();
        cut = len;
        if (ends_string && len > 1 && $urandom_range(0, 5) == 0)
            cut = $urandom_range(1, len - 1);
        for (int i = 0; i < cut; i++)
            send_byte(seq_bytes[i], ends_string && (i == cut - 1));
    endtask

    // strings of mixed characters until the byte target is reached
    task automatic send_text(input int n_bytes);
        int stop_at;
        int n_chars;
        int pick;
        char_kind_t kind;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            n_chars = $urandom_range(1, 10);
            for (int c = 0; c < n_chars; c++) begin
                pick = $urandom_range(0, 99);
                if (pick < 35)      kind = CH_ASCII;
                else if (pick < 60) kind = CH_TWO;
                else if (pick < 85) kind = CH_THREE;
                else if (pick < 93) kind = CH_FOUR;
                else                kind = CH_BAD_LEAD;
                send_char(kind, c == n_chars - 1);
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    // hand-picked bytes: field extremes, every lead kind, and the odd cases
    task automatic test_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        // two-byte, largest value
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // three-byte, euro sign then the top of the plane
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b0);
        // trailing bytes without the 10 prefix still count
        send_byte(8'hE0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        // four-byte sequence comes out as unsupported
        send_byte(8'hF7, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
        // bad leads: stray continuation and 11111xxx
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // string cut inside a two-, three- and four-byte sequence
        send_byte(8'hC3, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hF0, 1'b1);
        // single ascii and bad lead ending a string
        send_byte(8'h41, 1'b1);
        send_byte(8'hF8, 1'b1);
    endtask

    // mixed random text, bad leads and cut strings included, with gaps on both sides
    task automatic test_random_text();
        send_text(1200);
    endtask

    // raw random bytes, end-of-string now and then
    task automatic test_byte_noise();
        logic [7:0] r;
        for (int i = 0; i < 300; i++) begin
            r = 8'($urandom);
            send_byte(r, $urandom_range(0, 7) == 0);
        end
    endtask

    // receiver stalls for a long stretch while bytes keep coming
    task automatic test_back_pressure();
        hold_req = 1'b1;
        send_text(60);
        s_tvalid <= 1'b0;
        while (hold_req) @(posedge aclk);
    endtask

    // last stretch at full rate, no gaps anywhere
    task automatic test_full_rate();
        idle_on = 1'b0;
        send_text(300);
        // close any open sequence so nothing is left pending
        send_byte(8'h2E, 1'b1);
    endtask

    // ---------------------------------------------------------------- receiver

    // drives m_tready: random stall bursts, and the one long hold-off on request
    initial begin : ready_driver
        int n;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                for (int held = 0; held < HOLD_CYCLES; held++)
                    @(posedge aclk);
                m_tready <= 1'b1;
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 16);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // checks every accepted result word against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_unit = '{code_unit: m_tdata[15:0], byte_count: m_tdata[18:16],
                         unsupported: m_tuser[0], last_unit: m_tlast};
            if (m_tdata[23:19] != 5'd0)
                report_mismatch("tdata pad", int'(m_tdata[23:19]), 0);
            if (expected_units.size() == 0) begin
                report_mismatch("unexpected word", int'(got_unit), 0);
            end else begin
                want_unit = expected_units.pop_front();
                if (got_unit.code_unit != want_unit.code_unit)
                    report_mismatch("code_unit", int'(got_unit.code_unit),
                                    int'(want_unit.code_unit));
                if (got_unit.byte_count != want_unit.byte_count)
                    report_mismatch("byte_count", int'(got_unit.byte_count),
                                    int'(want_unit.byte_count));
                if (got_unit.unsupported != want_unit.unsupported)
                    report_mismatch("unsupported", int'(got_unit.unsupported),
                                    int'(want_unit.unsupported));
                if (got_unit.last_unit != want_unit.last_unit)
                    report_mismatch("last_unit", int'(got_unit.last_unit),
                                    int'(want_unit.last_unit));
            end
            units_seen++;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        idle_on = 1'b1;
        test_random_text();
        test_byte_noise();
        test_back_pressure();
        test_full_rate();

        // drain: wait for every expected word before the verdict
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (expected_units.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0 && expected_units.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/u2u_pkg.sv
rtl/u2u_step.sv
rtl/utf8_to_ucs2_decoder.sv
bench/tb_top.sv
